// File: rtl/qtt_pkg.sv
// ----------------------------------------------------------------------------
// qtt_pkg - shared types and constants for the quoted text tokenizer
// Scan modes, result word layout and the per-byte result bundle.
// ----------------------------------------------------------------------------
package qtt_pkg;

  localparam int unsigned MAX_TOKEN = 2048;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned LEN_W     = $clog2(MAX_TOKEN + 1);
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // reset limit 2048, clamped to the build limit
  localparam int unsigned LIMIT_RST = (MAX_TOKEN < 2048) ? MAX_TOKEN : 2048;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_QUOTE   = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  slash;
    len_t  len;
    logic  ovf;
  } scan_t;

  typedef struct packed {
    logic [7:0] data;
    logic       tok_end;
    logic       trunc;
  } word_t;

  // up to three words caused by one input byte
  typedef struct packed {
    logic [1:0]      cnt;
    word_t [2:0]     w;
  } bundle_t;

endpackage

// File: rtl/qtt_front.sv
// ----------------------------------------------------------------------------
// qtt_front - byte classifier and scan state
// Takes one byte a cycle unless q_full_i is set, updates the scan mode
// and token length, and packs the byte's words into a bundle for the queue.
// ----------------------------------------------------------------------------
module qtt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  qtt_pkg::len_t    limit_i,
  input  logic             q_full_i,
  output logic             push_o,
  output qtt_pkg::bundle_t bundle_o,
  output qtt_pkg::scan_t   scan_o
);
  import qtt_pkg::*;

  typedef struct packed {
    scan_t   s;
    bundle_t b;
  } work_t;

  scan_t scan_q, scan_d;
  work_t work;
  logic  accept;

  function automatic work_t f_put(work_t w, logic [7:0] data, logic tok_end, logic trunc);
    work_t r;
    word_t x;
    r = w;
    x = '{data: data, tok_end: tok_end, trunc: trunc};
    case (w.b.cnt)
      2'd0: begin r.b.w[0] = x; r.b.cnt = 2'd1; end
      2'd1: begin r.b.w[1] = x; r.b.cnt = 2'd2; end
      2'd2: begin r.b.w[2] = x; r.b.cnt = 2'd3; end
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic work_t f_content(work_t w, len_t limit, logic [7:0] data);
    work_t r;
    r = w;
    if (w.s.len < limit) begin
      r = f_put(r, data, 1'b0, 1'b0);
      r.s.len = w.s.len + len_t'(1);
    end else begin
      r.s.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t f_end(work_t w);
    work_t r;
    r = f_put(w, CH_NUL, 1'b1, w.s.ovf);
    r.s.len = '0;
    r.s.ovf = 1'b0;
    return r;
  endfunction

  function automatic work_t f_resolve(work_t w, len_t limit);
    work_t r;
    r = w;
    if (w.s.slash) begin
      r.s.slash = 1'b0;
      r = f_content(r, limit, CH_SLASH);
    end
    return r;
  endfunction

  function automatic work_t f_flush(work_t w, len_t limit);
    work_t r;
    r = w;
    if (w.s.mode == MODE_QUOTE) begin
      r = f_end(r);
    end else begin
      if (w.s.mode != MODE_COMMENT) r = f_resolve(r, limit);
      if (r.s.len != '0) r = f_end(r);
    end
    r.s = '{mode: MODE_NORMAL, slash: 1'b0, len: '0, ovf: 1'b0};
    return r;
  endfunction

  // classify the byte and build its bundle
  always_comb begin
    work   = '0;
    work.s = scan_q;
    if (data_byte_i == CH_NUL) begin
      work = f_flush(work, limit_i);
    end else begin
      case (scan_q.mode)
        MODE_QUOTE: begin
          if (data_byte_i == CH_QUOTE) begin
            work        = f_end(work);
            work.s.mode = MODE_NORMAL;
          end else begin
            work = f_content(work, limit_i, data_byte_i);
          end
        end
        MODE_COMMENT: begin
          if (data_byte_i == CH_LF) work.s.mode = MODE_NORMAL;
        end
        default: begin
          work.s.mode = MODE_NORMAL;
          if (data_byte_i == CH_SLASH) begin
            if (scan_q.slash) begin
              work.s.slash = 1'b0;
              work.s.mode  = MODE_COMMENT;
            end else begin
              work.s.slash = 1'b1;
            end
          end else begin
            work = f_resolve(work, limit_i);
            if (data_byte_i == CH_SPACE || data_byte_i == CH_TAB ||
                data_byte_i == CH_LF || data_byte_i == CH_CR) begin
              if (work.s.len != '0) work = f_end(work);
            end else if (data_byte_i == CH_QUOTE) begin
              work.s.mode = MODE_QUOTE;
            end else begin
              work = f_content(work, limit_i, data_byte_i);
            end
          end
        end
      endcase
      if (last_byte_i) work = f_flush(work, limit_i);
    end
  end

  // next state
  always_comb begin
    scan_d = accept ? work.s : scan_q;
  end

  // handshake and queue write
  always_comb begin
    in_stall_o = q_full_i;
    accept     = in_valid_i && !q_full_i;
    push_o     = accept && (work.b.cnt != 2'd0);
    bundle_o   = work.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '{mode: MODE_NORMAL, slash: 1'b0, len: '0, ovf: 1'b0};
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

// File: rtl/qtt_queue.sv
// ----------------------------------------------------------------------------
// qtt_queue - short bundle queue
// Decouples the classifier from the word sequencer.
// ----------------------------------------------------------------------------
module qtt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  qtt_pkg::bundle_t bundle_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output qtt_pkg::bundle_t head_o
);
  import qtt_pkg::*;

  bundle_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]    cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/qtt_back.sv
// ----------------------------------------------------------------------------
// qtt_back - word sequencer
// Walks the words of the head bundle onto the output channel.
// ----------------------------------------------------------------------------
module qtt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  qtt_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic [7:0]       token_byte_o,
  output logic             token_end_o,
  output logic             truncated_o,
  output logic             out_valid_o,
  input  logic             out_stall_i
);
  import qtt_pkg::*;

  logic [1:0] idx_q, idx_d;
  word_t      cur;
  logic       take;
  logic       last_word;

  always_comb begin
    case (idx_q)
      2'd0:    cur = head_i.w[0];
      2'd1:    cur = head_i.w[1];
      default: cur = head_i.w[2];
    endcase
  end

  always_comb begin
    out_valid_o  = !empty_i;
    token_byte_o = cur.data;
    token_end_o  = cur.tok_end;
    truncated_o  = cur.trunc;
    take         = out_valid_o && !out_stall_i;
    last_word    = (idx_q == head_i.cnt - 2'd1);
    pop_o        = take && last_word;
    idx_d        = idx_q;
    if (take) idx_d = last_word ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: rtl/quoted_text_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_text_tokenizer - whitespace tokenizer with quotes and line comments
// Splits a byte stream into token bytes, each token closed by an end word.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | data_byte_i, last_byte_i, in_valid_i    | in, in_stall_o out
//  out     | token_byte_o, token_end_o, truncated_o  | out, out_stall_i in
//  cfg     | cfg_we_i, cfg_wdata_i                   | in, write only
//
//  One byte is taken per cycle while the queue is not full; the classifier
//  decides all words a byte causes in that same cycle and queues them as
//  one bundle. The sequencer drains one word per cycle unless out_stall_i
//  is high, so bytes causing two or three words back up; the four-entry
//  bundle queue absorbs these and input stalls only once it fills.
//  Reset (rst_ni low, async) clears scan state and the queue, and sets the
//  length limit to 2048 clamped to MAX_TOKEN.
//  The limit register is stored pre-clamped to 1..MAX_TOKEN.
// ----------------------------------------------------------------------------
module quoted_text_tokenizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic [7:0]                token_byte_o,
  output logic                      token_end_o,
  output logic                      truncated_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  logic                      cfg_we_i,
  input  logic [qtt_pkg::CFG_W-1:0] cfg_wdata_i
);
  import qtt_pkg::*;

  len_t    limit_q, limit_d;
  logic    push, pop, q_full, q_empty;
  bundle_t bundle, head;
  scan_t   scan;

  // clamp on write: 0 acts as 1, anything above MAX_TOKEN as MAX_TOKEN
  always_comb begin
    limit_d = limit_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        limit_d = len_t'(1);
      end else if ({1'b0, cfg_wdata_i} > (CFG_W + 1)'(MAX_TOKEN)) begin
        limit_d = len_t'(MAX_TOKEN);
      end else begin
        limit_d = len_t'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= len_t'(LIMIT_RST);
    end else begin
      limit_q <= limit_d;
    end
  end

  // front: classify bytes, keep scan state
  qtt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .limit_i     (limit_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .bundle_o    (bundle),
    .scan_o      (scan)
  );

  // bundle queue between the two halves
  qtt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (q_full),
    .pop_i    (pop),
    .empty_o  (q_empty),
    .head_o   (head)
  );

  // back: one word per cycle onto the output unless out_stall_i is set
  qtt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .token_byte_o (token_byte_o),
    .token_end_o  (token_end_o),
    .truncated_o  (truncated_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

  // end words carry a zero byte
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_end_o |-> token_byte_o == 8'h00)
    else $error("token end word with non-zero byte");

  // truncation is only reported on end words
  a_trunc_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !token_end_o |-> !truncated_o)
    else $error("truncation flag on a content word");

  // a pending slash cannot survive into a quoted string
  a_no_slash_in_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan.mode == MODE_QUOTE |-> !scan.slash)
    else $error("slash pending inside quotes");

  // the length limit is within its legal range after every config write
  a_limit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we_i) |-> limit_q != '0 && limit_q <= len_t'(MAX_TOKEN))
    else $error("length limit out of range");

endmodule
